FILE: src/rdc_pkg.sv
// ----------------------------------------------------------------------------
// rdc_pkg: shared definitions for the radix digit converter
// Field widths, the radix reset value, the sequencer state type and the
// helpers that clamp the radix and map a digit to its ASCII character.
// ----------------------------------------------------------------------------
`default_nettype none

package rdc_pkg;

  localparam int MAX_DIGITS  = 64;
  localparam int RESULT_CAP  = 63;
  localparam int VALUE_W     = 63;
  localparam int RADIX_W     = 5;
  localparam int DIGIT_W     = 4;
  localparam int CHAR_W      = 7;
  localparam int COUNT_W     = 6;
  localparam int STEP_W      = $clog2(VALUE_W);

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(16);
  localparam logic [CHAR_W-1:0]  CHAR_ZERO   = CHAR_W'(48);
  localparam logic [CHAR_W-1:0]  CHAR_UPPER_A = CHAR_W'(65);
  localparam logic [DIGIT_W-1:0] DIGIT_TEN   = DIGIT_W'(10);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_SHOW
  } rdc_state_e;

  // Out-of-range radix settings saturate to the nearest legal base.
  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    else if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_TEN) c = CHAR_ZERO + CHAR_W'(d);
    else c = CHAR_UPPER_A + CHAR_W'(d - DIGIT_TEN);
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: src/rdc_divider.sv
// ----------------------------------------------------------------------------
// rdc_divider: bit-serial divider by the radix
// Restoring long division of the value by a small divisor, one quotient bit
// per cycle. Quotient and remainder are valid when done pulses.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_divider import rdc_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [VALUE_W-1:0]  dividend_i,
  input  wire logic [RADIX_W-1:0]  divisor_i,
  output logic                     done_o,
  output logic [VALUE_W-1:0]       quotient_o,
  output logic [DIGIT_W-1:0]       remainder_o
);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [VALUE_W-1:0]  quot_q, quot_d;
  logic [DIGIT_W-1:0]  rem_q, rem_d;
  logic [RADIX_W-1:0]  dvs_q, dvs_d;
  logic [RADIX_W-1:0]  trial;
  logic                fits;

  // The remainder stays below the divisor, so it shifts into a 5-bit trial.
  assign trial = {rem_q, quot_q[VALUE_W-1]};
  assign fits  = (trial >= dvs_q);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quot_d = {quot_q[VALUE_W-2:0], fits};
      rem_d  = fits ? DIGIT_W'(trial - dvs_q) : DIGIT_W'(trial);
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(VALUE_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      quot_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
      quot_q <= quot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quot_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

FILE: src/radix_digit_converter_top.sv
// ----------------------------------------------------------------------------
// radix_digit_converter_top: integer to radix digit string
// Converts a non-negative value into ASCII digits in a configured radix.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_stall_o) takes one value per beat.
//   Each value yields one output beat per digit, most significant first, on
//   out_valid_o / out_stall_i, each with the digit count and a last mark.
//   The user must write the radix register (radix_we_i / radix_i) only while
//   idle; the block does not check. Settings below 2 or above 16 saturate.
// Operation:
//   Every digit takes one pass of the bit-serial divider, after which its
//   remainder is stored. Emitting a digit reads the store, then presents
//   the output beat. The block takes no new value until its last digit
//   beat is accepted. A stalled output beat holds its payload until taken.
// Reset:
//   Reset returns the sequencer to idle and the radix to 10. The digit
//   store needs no clearing, since every entry read was written first.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_digit_converter_top import rdc_pkg::*; #(
  parameter int MaxDigits = MAX_DIGITS
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                radix_we_i,
  input  wire logic [RADIX_W-1:0]  radix_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [VALUE_W-1:0]  value_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [CHAR_W-1:0]        digit_char_o,
  output logic [COUNT_W-1:0]       digit_count_o,
  output logic                     is_last_o
);

  localparam int Cap   = (MaxDigits < RESULT_CAP) ? MaxDigits : RESULT_CAP;
  localparam int CntW  = $clog2(Cap + 1);
  localparam int AddrW = $clog2(MaxDigits);

  rdc_state_e          state_q, state_d;
  logic [RADIX_W-1:0]  radix_q;
  logic [CntW-1:0]     cnt_q, cnt_d, cnt_inc;
  logic [AddrW-1:0]    pos_q, pos_d;
  logic [DIGIT_W-1:0]  rd_q;
  logic [DIGIT_W-1:0]  mem [MaxDigits];
  logic                mem_we;
  logic                more;
  logic                div_start;
  logic                div_done;
  logic [VALUE_W-1:0]  div_dividend;
  logic [VALUE_W-1:0]  div_quot;
  logic [DIGIT_W-1:0]  div_rem;
  logic                out_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
    end else if (radix_we_i) begin
      radix_q <= radix_i;
    end
  end

  assign cnt_inc  = cnt_q + CntW'(1);
  assign more     = (div_quot != '0) && (cnt_inc < CntW'(Cap));
  assign out_take = out_valid_o && !out_stall_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_DIV;
      ST_DIV:  if (div_done && !more) state_d = ST_READ;
      ST_READ: state_d = ST_SHOW;
      ST_SHOW: begin
        if (!out_stall_i) state_d = (pos_q == '0) ? ST_IDLE : ST_READ;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_stall_o   = 1'b1;
    out_valid_o  = 1'b0;
    div_start    = 1'b0;
    mem_we       = 1'b0;
    div_dividend = div_quot;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        div_start    = in_valid_i;
        div_dividend = value_i;
      end
      ST_DIV: begin
        mem_we    = div_done;
        div_start = div_done && more;
      end
      ST_READ: ;
      ST_SHOW: out_valid_o = 1'b1;
      default: ;
    endcase
  end

  // Digit counter and read pointer.
  always_comb begin
    cnt_d = cnt_q;
    pos_d = pos_q;
    if (state_q == ST_IDLE && in_valid_i) begin
      cnt_d = '0;
    end else if (mem_we) begin
      cnt_d = cnt_inc;
      // The pointer starts at the digit just written, the most significant.
      pos_d = AddrW'(cnt_q);
    end else if (out_take && pos_q != '0) begin
      pos_d = pos_q - AddrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cnt_q[AddrW-1:0]] <= div_rem;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      rd_q <= mem[pos_q];
    end
  end

  rdc_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (eff_radix(radix_q)),
    .done_o      (div_done),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  assign digit_char_o  = to_ascii(rd_q);
  assign digit_count_o = COUNT_W'(cnt_q);
  assign is_last_o     = (pos_q == '0);

  a_store_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (cnt_q < CntW'(Cap)))
    else $error("digit store written past its capacity");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside a division pass");

  a_pos_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (CntW'(pos_q) < cnt_q))
    else $error("read pointer beyond the digits held");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_take && is_last_o) |=> (state_q == ST_IDLE))
    else $error("sequencer kept running after the last digit beat");

  a_count_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && $past(out_valid_o)) |-> $stable(cnt_q))
    else $error("digit count changed during emission");

endmodule

`default_nettype wire

FILE: verif/tb_radix_digit_converter_top.sv
// ----------------------------------------------------------------------------
// tb_radix_digit_converter_top: self-checking bench for the digit converter
// Feeds values through the valid/stall input channel and predicts the ASCII
// digit beats for the current radix. Each output beat is checked field by
// field. Both sides idle at random, and the receiver also holds off once
// for a long stretch. Radix settings change only while the block is idle.
// ----------------------------------------------------------------------------

module tb_radix_digit_converter_top import rdc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 600;
  localparam int DIGIT_CAP   = (MAX_DIGITS < RESULT_CAP) ? MAX_DIGITS : RESULT_CAP;

  typedef struct packed {
    logic [CHAR_W-1:0]  digit_char;
    logic [COUNT_W-1:0] digit_count;
    logic               is_last;
  } digit_beat_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               radix_we_i = 1'b0;
  logic [RADIX_W-1:0] radix_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [VALUE_W-1:0] value_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [CHAR_W-1:0]  digit_char_o;
  logic [COUNT_W-1:0] digit_count_o;
  logic               is_last_o;

  logic [VALUE_W-1:0] value_queue [$];
  digit_beat_t        digits_due [$];
  logic [RADIX_W-1:0] radix_setting = RADIX_RESET;

  bit calm = 1'b0;
  int values_taken = 0;
  int beats_checked = 0;
  int radix_writes = 0;
  int mismatches = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int hold_count = 0;
  logic long_hold = 1'b0;

  radix_digit_converter_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .radix_we_i    (radix_we_i),
    .radix_i       (radix_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .digit_char_o  (digit_char_o),
    .digit_count_o (digit_count_o),
    .is_last_o     (is_last_o)
  );

  always #2 clk_i = ~clk_i;

  // Divides by the clamped radix and queues the digits most significant first.
  function automatic void expand_digits(input logic [VALUE_W-1:0] value);
    logic [VALUE_W-1:0] quot;
    logic [DIGIT_W-1:0] rems [DIGIT_CAP];
    logic [VALUE_W-1:0] base;
    digit_beat_t        beat;
    int                 n;
    if (radix_setting < RADIX_MIN) base = VALUE_W'(RADIX_MIN);
    else if (radix_setting > RADIX_MAX) base = VALUE_W'(RADIX_MAX);
    else base = VALUE_W'(radix_setting);
    quot = value;
    n = 0;
    do begin
      rems[n] = DIGIT_W'(quot % base);
      n++;
      quot = quot / base;
    end while (quot != '0 && n < DIGIT_CAP);
    for (int k = n - 1; k >= 0; k--) begin
      if (rems[k] < 4'd10) beat.digit_char = CHAR_ZERO + CHAR_W'(rems[k]);
      else beat.digit_char = CHAR_UPPER_A + CHAR_W'(rems[k] - 4'd10);
      beat.digit_count = COUNT_W'(n);
      beat.is_last     = (k == 0);
      digits_due.push_back(beat);
    end
  endfunction

  // Mostly short values keep the run fast; a few use the full width.
  function automatic logic [VALUE_W-1:0] random_value();
    logic [63:0] raw;
    int unsigned width_sel;
    raw = {$urandom(), $urandom()};
    width_sel = $urandom_range(0, 9);
    if (width_sel == 0) return '0;
    if (width_sel <= 2) return raw[VALUE_W-1:0];
    return raw[VALUE_W-1:0] & ((VALUE_W'(1) << $urandom_range(1, 24)) - VALUE_W'(1));
  endfunction

  function automatic int draw_gap();
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 13);
  endfunction

  // Input side: one beat per value, with a random gap after each accepted one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      value_i    <= '0;
      send_gap = 0;
    end else if (!(in_valid_i && in_stall_o)) begin
      if (in_valid_i) begin
        expand_digits(value_i);
        values_taken++;
        send_gap = draw_gap();
      end
      if (send_gap == 0 && value_queue.size() > 0) begin
        in_valid_i <= 1'b1;
        value_i    <= value_queue.pop_front();
      end else begin
        in_valid_i <= 1'b0;
        if (send_gap > 0) send_gap--;
      end
    end
  end

  // Long receiver hold-off, started on request from the stimulus sequence.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_hold <= 1'b0;
      hold_count = 0;
    end else if (hold_count > 0) begin
      hold_count--;
      long_hold <= (hold_count != 0);
    end else if (holds_asked != holds_done) begin
      holds_done++;
      hold_count = HOLD_CYCLES;
      long_hold <= 1'b1;
    end
  end

  // Output side: checks each accepted beat and draws the next stall.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        digit_beat_t exp_beat;
        digit_beat_t got_beat;
        got_beat = '{digit_char_o, digit_count_o, is_last_o};
        if (digits_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected digit beat: char %0d count %0d last %0b",
                     got_beat.digit_char, got_beat.digit_count, got_beat.is_last);
        end else begin
          exp_beat = digits_due.pop_front();
          if (exp_beat.digit_char !== got_beat.digit_char ||
              exp_beat.digit_count !== got_beat.digit_count ||
              exp_beat.is_last !== got_beat.is_last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("digit beat %0d: expected char %0d count %0d last %0b, got %0d %0d %0b",
                       beats_checked, exp_beat.digit_char, exp_beat.digit_count,
                       exp_beat.is_last, got_beat.digit_char, got_beat.digit_count,
                       got_beat.is_last);
          end
        end
        beats_checked++;
        recv_gap = draw_gap();
      end
      if (long_hold) begin
        out_stall_i <= 1'b1;
      end else if (recv_gap > 0) begin
        out_stall_i <= 1'b1;
        recv_gap--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic wait_idle();
    do @(negedge clk_i);
    while (value_queue.size() != 0 || in_valid_i || digits_due.size() != 0);
  endtask

  task automatic set_radix(input logic [RADIX_W-1:0] r);
    wait_idle();
    @(posedge clk_i);
    radix_we_i <= 1'b1;
    radix_i    <= r;
    @(posedge clk_i);
    radix_we_i    <= 1'b0;
    radix_setting = r;
    radix_writes++;
  endtask

  initial begin
    logic [RADIX_W-1:0] pick;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset radix of ten: zero, single digits, carries and the widest value.
    value_queue.push_back('0);
    value_queue.push_back(VALUE_W'(1));
    value_queue.push_back(VALUE_W'(9));
    value_queue.push_back(VALUE_W'(10));
    value_queue.push_back(VALUE_W'(99));
    value_queue.push_back(63'd1000000000000000000);
    value_queue.push_back({VALUE_W{1'b1}});

    set_radix(RADIX_W'(16));
    value_queue.push_back(VALUE_W'(15));
    value_queue.push_back(63'h0123_4567_89AB_CDEF);
    value_queue.push_back({VALUE_W{1'b1}});

    // Binary with the full width gives the longest digit string.
    set_radix(RADIX_W'(2));
    value_queue.push_back(VALUE_W'(1));
    value_queue.push_back(63'h4000_0000_0000_0000);
    value_queue.push_back(63'h2AAA_AAAA_AAAA_AAAA);
    value_queue.push_back({VALUE_W{1'b1}});

    // Settings outside two through sixteen saturate.
    set_radix(RADIX_W'(0));
    value_queue.push_back(VALUE_W'(5));
    value_queue.push_back('0);
    set_radix(RADIX_W'(31));
    value_queue.push_back(63'h7EDC_BA98_7654_3210);
    set_radix(RADIX_W'(1));
    value_queue.push_back(VALUE_W'(6));
    set_radix(RADIX_W'(17));
    value_queue.push_back(VALUE_W'(255));
    set_radix(RADIX_W'(3));
    value_queue.push_back({VALUE_W{1'b1}});

    for (int p = 0; p < 8; p++) begin
      if ($urandom_range(0, 4) == 0) pick = RADIX_W'($urandom_range(0, 31));
      else pick = RADIX_W'($urandom_range(2, 16));
      set_radix(pick);
      calm = (p % 3 == 1);
      // The receiver holds off while values keep coming, so the input backs up.
      if (p == 4) holds_asked++;
      repeat (13) value_queue.push_back(random_value());
    end

    wait_idle();
    repeat (200) @(posedge clk_i);
    $display("Converted %0d values into %0d digit beats across %0d radix writes,",
             values_taken, beats_checked, radix_writes);
    $display("including saturated radix settings and one long receiver hold-off.");
    if (mismatches == 0 && digits_due.size() == 0) begin
      $display("tb_radix_digit_converter_top OK");
    end else begin
      $display("tb_radix_digit_converter_top NOT OK");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d digit beats still expected", digits_due.size());
    $display("tb_radix_digit_converter_top NOT OK");
    $finish;
  end

endmodule

FILE: files.f
src/rdc_pkg.sv
src/rdc_divider.sv
src/radix_digit_converter_top.sv
verif/tb_radix_digit_converter_top.sv
